/* hdl/bm118_pkg.sv */
// Shared types and constants for the cartridge bank mapper.
// Used by bm118_regs, bm118_xlate and cartridge_bank_mapper_118; no dependencies.
`timescale 1ns / 1ps

package bm118_pkg;

    // Request kinds carried on s_tuser
    typedef enum logic [1:0] {
        FUNC_CPU_WRITE = 2'd0,
        FUNC_PRG_READ  = 2'd1,
        FUNC_CHR_READ  = 2'd2,
        FUNC_UNUSED    = 2'd3
    } func_t;

    localparam logic [15:0] DECODE_MASK     = 16'hE001;
    localparam logic [15:0] SELECT_ADDR     = 16'h8000;
    localparam logic [15:0] BANK_DATA_ADDR  = 16'h8001;
    localparam int          CHR_SWAP_BIT    = 7;
    localparam int          PRG_SWAP_BIT    = 6;
    localparam logic [7:0]  PRG_BANK_MASK   = 8'h3F;
    localparam logic [7:0]  PRG_SIZE_RESET  = 8'd2;

    localparam int BANK_REGS = 8;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    // Mapper state as seen by the translation logic
    typedef struct packed {
        logic [7:0]                select_byte;
        logic [BANK_REGS-1:0][7:0] banks;
        logic [7:0]                prg_size;
    } map_state_t;

    // Register write request from the decode
    typedef struct packed {
        logic       select_we;
        logic       bank_we;
        logic [7:0] data;
    } reg_wr_t;

    typedef struct packed {
        logic        mapped;
        logic        rom_kind;
        logic [7:0]  rom_bank;
        logic [12:0] bank_offset;
    } map_result_t;

endpackage

/* hdl/bm118_regs.sv */
// Select byte, eight bank data registers and the program ROM size register.
// Depends on bm118_pkg.
`timescale 1ns / 1ps

module bm118_regs
    import bm118_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wen,
    input  logic [7:0] cfg_wdata,
    input  reg_wr_t    wr,
    output map_state_t state
);

    logic [7:0]                select_reg, select_next;
    logic [BANK_REGS-1:0][7:0] banks_reg, banks_next;
    logic [7:0]                size_reg, size_next;

    always_comb begin
        select_next = select_reg;
        banks_next  = banks_reg;
        size_next   = size_reg;
        if (wr.select_we) begin
            select_next = wr.data;
        end
        // data goes to the register picked by the low select bits
        if (wr.bank_we) begin
            banks_next[select_reg[2:0]] = wr.data;
        end
        if (cfg_wen) begin
            size_next = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            select_reg <= '0;
            banks_reg  <= '0;
            size_reg   <= PRG_SIZE_RESET;
        end else begin
            select_reg <= select_next;
            banks_reg  <= banks_next;
            size_reg   <= size_next;
        end
    end

    assign state.select_byte = select_reg;
    assign state.banks       = banks_reg;
    assign state.prg_size    = size_reg;

endmodule

/* hdl/bm118_xlate.sv */
// Address decode and bank translation for one request word.
// Depends on bm118_pkg.
`timescale 1ns / 1ps

module bm118_xlate
    import bm118_pkg::*;
(
    input  logic        valid,
    input  func_t       func,
    input  logic [15:0] bus_address,
    input  logic [7:0]  write_data,
    input  map_state_t  state,
    output reg_wr_t     wr,
    output map_result_t result
);

    logic [15:0] dec;
    logic [7:0]  last2;
    logic [1:0]  prg_slot;
    logic [2:0]  chr_slot;
    logic [2:0]  chr_reg;
    logic [7:0]  chr_raw;
    logic [7:0]  prg_bank;
    logic [7:0]  chr_bank;

    assign dec   = bus_address & DECODE_MASK;
    assign last2 = {state.prg_size[6:0], 1'b0} - 8'd2;

    always_comb begin
        prg_slot = bus_address[14:13];
        // swap the $8000 and $C000 windows
        if (state.select_byte[PRG_SWAP_BIT] && !prg_slot[0]) begin
            prg_slot = prg_slot ^ 2'b10;
        end
        case (prg_slot)
            2'd0:    prg_bank = state.banks[6] & PRG_BANK_MASK;
            2'd1:    prg_bank = state.banks[7] & PRG_BANK_MASK;
            2'd2:    prg_bank = last2;
            default: prg_bank = last2 | 8'd1;
        endcase
    end

    always_comb begin
        chr_slot = bus_address[12:10] ^ {state.select_byte[CHR_SWAP_BIT], 2'b00};
        // 2KB pairs in the low half, 1KB banks from reg2 up in the high half
        chr_reg  = chr_slot[2] ? (chr_slot - 3'd2) : {2'b00, chr_slot[1]};
        chr_raw  = state.banks[chr_reg];
        chr_bank = chr_slot[2] ? chr_raw : {chr_raw[7:1], chr_slot[0]};
    end

    always_comb begin
        wr.select_we = valid && (func == FUNC_CPU_WRITE) && (dec == SELECT_ADDR);
        wr.bank_we   = valid && (func == FUNC_CPU_WRITE) && (dec == BANK_DATA_ADDR);
        wr.data      = write_data;

        result = '0;
        case (func)
            FUNC_PRG_READ: begin
                if (bus_address[15]) begin
                    result.mapped      = 1'b1;
                    result.rom_bank    = prg_bank;
                    result.bank_offset = bus_address[12:0];
                end
            end
            FUNC_CHR_READ: begin
                result.rom_kind = 1'b1;
                if (bus_address[15:13] == 3'd0) begin
                    result.mapped      = 1'b1;
                    result.rom_bank    = chr_bank;
                    result.bank_offset = {3'b000, bus_address[9:0]};
                end
            end
            default: begin
                result = '0;
            end
        endcase
    end

endmodule

/* hdl/cartridge_bank_mapper_118.sv */
// Top level of the cartridge bank mapper: input register, translation, result register.
// Depends on bm118_pkg, bm118_regs and bm118_xlate.
`timescale 1ns / 1ps

// Translates CPU and PPU bus accesses into a ROM bank and an offset, one word per
// clock while the output is not stalled. Each accepted word is held in the input
// register and then moves to the result register, which drives m_tvalid/m_tdata;
// a stalled output keeps it in the input register. Register writes update the bank
// state as they leave the input register, so every later read sees them. Every word,
// writes included, returns exactly one result word. cfg_wen loads the program ROM
// size (16KB units).

module cartridge_bank_mapper_118
    import bm118_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wen,
    input  logic [7:0]             cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // bus_address[15:0], write_data[23:16]
    input  logic [1:0]             s_tuser,   // func[1:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // rom_bank[7:0], bank_offset[20:8], zero[23:21]
    output logic [1:0]             m_tuser    // mapped[0], rom_kind[1]
);

    logic                  in_valid_reg, in_valid_next;
    logic [IN_TDATA_W-1:0] in_data_reg, in_data_next;
    logic [1:0]            in_func_reg, in_func_next;
    logic                  out_valid_reg, out_valid_next;
    map_result_t           out_res_reg, out_res_next;

    logic        out_adv;
    logic        process;
    map_state_t  state;
    reg_wr_t     wr;
    map_result_t result;

    assign out_adv  = !out_valid_reg || m_tready;
    assign process  = in_valid_reg && out_adv;
    assign s_tready = !in_valid_reg || out_adv;

    always_comb begin
        in_valid_next  = in_valid_reg;
        in_data_next   = in_data_reg;
        in_func_next   = in_func_reg;
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (out_adv) begin
            out_valid_next = in_valid_reg;
            out_res_next   = result;
        end
        if (s_tready) begin
            in_valid_next = s_tvalid;
            in_data_next  = s_tdata;
            in_func_next  = s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        in_data_reg <= in_data_next;
        in_func_reg <= in_func_next;
        out_res_reg <= out_res_next;
    end

    bm118_regs u_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .wr        (wr),
        .state     (state)
    );

    bm118_xlate u_xlate (
        .valid       (process),
        .func        (func_t'(in_func_reg)),
        .bus_address (in_data_reg[15:0]),
        .write_data  (in_data_reg[23:16]),
        .state       (state),
        .wr          (wr),
        .result      (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_res_reg.bank_offset, out_res_reg.rom_bank};
    assign m_tuser  = {out_res_reg.rom_kind, out_res_reg.mapped};

`ifndef ASSERT_OFF
    a_unmapped_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("unmapped result carries a bank or offset");

    a_chr_offset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] && m_tuser[1] |-> m_tdata[20:18] == 3'b000)
        else $error("pattern offset exceeds 1KB");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_adv |=> in_valid_reg && $stable(in_data_reg))
        else $error("input register lost a word while stalled");

    a_write_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr.select_we && wr.bank_we))
        else $error("select and bank write in the same cycle");
`endif

endmodule
